// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the order table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define OVWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, also during reset.
`define OVWA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ovwa_pkg.sv =====
// Package with the types, codes and constants of the order table block.
`default_nettype none

package ovwa_pkg;

  localparam int unsigned ORDER_SLOTS_DEF = 65536;
  localparam int unsigned PROBE_LIMIT_DEF = 8;
  localparam int unsigned STOCK_SLOTS_DEF = 65536;

  // Multiplicative hash constant and the fold shift of the home slot hash.
  localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned HASH_SHIFT = 29;

  typedef enum logic [2:0] {
    MODE_ADD,
    MODE_EXEC,
    MODE_EXEC_PRICE,
    MODE_CANCEL,
    MODE_REPLACE,
    MODE_TRADE,
    MODE_BROKEN,
    MODE_CROSS
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_KL_CL,
    MUL_KH_CL,
    MUL_KL_CH,
    MUL_ACC
  } mul_sel_e;

  typedef enum logic [1:0] {
    HASH_HOLD,
    HASH_LOAD,
    HASH_ADD_HI
  } hash_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INSERT,
    WR_ERASE,
    WR_OVERWRITE
  } wr_kind_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_MSG,
    ACC_STORED_PRICE,
    ACC_STORED_SUB
  } acc_sel_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] stock_locate;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic [31:0] share_count;
    logic [31:0] price_raw;
  } ovwa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        stock_out;
    logic signed [63:0] notional_total;
    logic signed [47:0] volume_total;
  } ovwa_out_t;

  typedef struct packed {
    logic     clear;
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    hash_op_e hash_op;
    logic     key_sel;
    logic     scan_clr;
    logic     scan_run;
    wr_kind_e wr_kind;
    logic     set_miss;
    logic     set_full;
    acc_sel_e acc_sel;
    logic     acc_wr;
  } ovwa_cmd_t;

  typedef struct packed {
    logic  clear_done;
    logic  scan_done;
    logic  hit;
    logic  has_free;
    logic  out_free;
    mode_e mode;
  } ovwa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ovwa_dp.sv =====
// Datapath: order table and stock memories, hash, probe scan and accumulators.
`default_nettype none

module ovwa_dp import ovwa_pkg::*; #(
  parameter int unsigned ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int unsigned PROBE_LIMIT = PROBE_LIMIT_DEF,
  parameter int unsigned STOCK_SLOTS = STOCK_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ovwa_cmd_t  cmd_i,
  output ovwa_stat_t stat_o,
  input  ovwa_in_t   in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ovwa_out_t  out_o
);

  localparam int unsigned TW        = $clog2(ORDER_SLOTS);
  localparam int unsigned SW        = $clog2(STOCK_SLOTS);
  localparam int unsigned CLR_DEPTH = (ORDER_SLOTS > STOCK_SLOTS) ? ORDER_SLOTS : STOCK_SLOTS;
  localparam int unsigned CW        = $clog2(CLR_DEPTH);
  localparam int unsigned PW        = $clog2(PROBE_LIMIT + 1);

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] stock;
    logic [31:0] price;
    logic [31:0] shares;
  } entry_t;

  typedef struct packed {
    logic [63:0] notional;
    logic [47:0] volume;
  } stk_t;

  entry_t tbl_mem [ORDER_SLOTS];
  stk_t   stk_mem [STOCK_SLOTS];

  ovwa_in_t    in_q;
  logic [63:0] prod_q, hash_q;
  logic [31:0] acc_sh_q;
  logic        sub_q;
  status_e     status_q;

  logic [CW-1:0] clr_cnt_q;
  logic [PW-1:0] iss_cnt_q, cmp_cnt_q;
  logic          rd_pend_q;
  logic [TW-1:0] rd_slot_q;
  entry_t        tbl_rd_q;
  logic          hit_q, free_q;
  logic [TW-1:0] hit_slot_q, free_slot_q;
  entry_t        hit_ent_q;
  stk_t          stk_rd_q;

  logic          out_valid_q;
  ovwa_out_t     out_q;

  logic [63:0] key;
  logic [31:0] mul_a, mul_b, acc_sh;
  logic [63:0] prod_d, h_mix;
  logic [TW-1:0] home, probe_addr;
  logic          issue;
  logic [SW-1:0] stk_idx;
  logic          tbl_we;
  logic [TW-1:0] tbl_wa;
  entry_t        tbl_wd;
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  stk_t          stk_wd, stk_new;
  logic          out_free;

  assign key     = cmd_i.key_sel ? in_q.new_order_ref : in_q.order_ref;
  assign stk_idx = in_q.stock_locate[SW-1:0];

  // Shared 32x32 multiplier: hash partial products or price times shares.
  always_comb begin
    mul_a  = 32'h0;
    mul_b  = 32'h0;
    acc_sh = 32'h0;
    case (cmd_i.mul_sel)
      MUL_KL_CL: begin
        mul_a = key[31:0];
        mul_b = HASH_MULT[31:0];
      end
      MUL_KH_CL: begin
        mul_a = key[63:32];
        mul_b = HASH_MULT[31:0];
      end
      MUL_KL_CH: begin
        mul_a = key[31:0];
        mul_b = HASH_MULT[63:32];
      end
      default: begin
        case (cmd_i.acc_sel)
          ACC_MSG: begin
            mul_a  = in_q.price_raw;
            mul_b  = in_q.share_count;
            acc_sh = in_q.share_count;
          end
          ACC_STORED_PRICE: begin
            mul_a  = hit_ent_q.price;
            mul_b  = in_q.share_count;
            acc_sh = in_q.share_count;
          end
          ACC_STORED_SUB: begin
            mul_a  = hit_ent_q.price;
            mul_b  = hit_ent_q.shares;
            acc_sh = hit_ent_q.shares;
          end
          default: ;
        endcase
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign h_mix      = hash_q ^ (hash_q >> HASH_SHIFT);
  assign home       = h_mix[TW-1:0];
  assign probe_addr = home + TW'(iss_cnt_q);
  assign issue      = cmd_i.scan_run && (iss_cnt_q != PW'(PROBE_LIMIT));

  // Table write port.
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = hit_slot_q;
    tbl_wd = hit_ent_q;
    if (cmd_i.clear) begin
      tbl_we = 1'b1;
      tbl_wa = clr_cnt_q[TW-1:0];
      tbl_wd = '0;
    end else begin
      case (cmd_i.wr_kind)
        WR_INSERT: begin
          tbl_we        = 1'b1;
          tbl_wa        = free_slot_q;
          tbl_wd.valid  = 1'b1;
          tbl_wd.key    = key;
          tbl_wd.stock  = in_q.stock_locate;
          tbl_wd.price  = in_q.price_raw;
          tbl_wd.shares = in_q.share_count;
        end
        WR_ERASE: begin
          tbl_we       = 1'b1;
          tbl_wd.valid = 1'b0;
        end
        WR_OVERWRITE: begin
          tbl_we        = 1'b1;
          tbl_wd.price  = in_q.price_raw;
          tbl_wd.shares = in_q.share_count;
        end
        default: ;
      endcase
    end
  end

  // Accumulator update and stock write port.
  always_comb begin
    if (sub_q) begin
      stk_new.notional = stk_rd_q.notional - prod_q;
      stk_new.volume   = stk_rd_q.volume - {16'h0, acc_sh_q};
    end else begin
      stk_new.notional = stk_rd_q.notional + prod_q;
      stk_new.volume   = stk_rd_q.volume + {16'h0, acc_sh_q};
    end
    if (cmd_i.clear) begin
      stk_we = 1'b1;
      stk_wa = clr_cnt_q[SW-1:0];
      stk_wd = '0;
    end else begin
      stk_we = cmd_i.acc_wr;
      stk_wa = stk_idx;
      stk_wd = stk_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_q <= tbl_mem[probe_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_idx];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q   <= prod_d;
      acc_sh_q <= acc_sh;
      sub_q    <= (cmd_i.acc_sel == ACC_STORED_SUB);
    end
    case (cmd_i.hash_op)
      HASH_LOAD:   hash_q <= prod_q;
      HASH_ADD_HI: hash_q <= hash_q + {prod_q[31:0], 32'h0};
      default: ;
    endcase
    if (cmd_i.load) begin
      status_q <= STAT_DONE;
    end else if (cmd_i.set_full) begin
      status_q <= STAT_FULL;
    end else if (cmd_i.set_miss) begin
      status_q <= STAT_MISS;
    end
    rd_slot_q <= probe_addr;
    if (rd_pend_q && !hit_q && tbl_rd_q.valid && (tbl_rd_q.key == key)) begin
      hit_slot_q <= rd_slot_q;
      hit_ent_q  <= tbl_rd_q;
    end
    if (rd_pend_q && !free_q && !tbl_rd_q.valid) begin
      free_slot_q <= rd_slot_q;
    end
    if (cmd_i.acc_wr) begin
      out_q.status         <= status_q;
      out_q.stock_out      <= in_q.stock_locate;
      out_q.notional_total <= stk_new.notional;
      out_q.volume_total   <= stk_new.volume;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      iss_cnt_q   <= '0;
      cmp_cnt_q   <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      rd_pend_q <= issue;
      if (cmd_i.scan_clr) begin
        iss_cnt_q <= '0;
        cmp_cnt_q <= '0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
      end else begin
        if (issue) begin
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
        if (rd_pend_q) begin
          cmp_cnt_q <= cmp_cnt_q + 1'b1;
          if (tbl_rd_q.valid && (tbl_rd_q.key == key)) begin
            hit_q <= 1'b1;
          end
          if (!tbl_rd_q.valid) begin
            free_q <= 1'b1;
          end
        end
      end
      if (cmd_i.acc_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.clear_done = (clr_cnt_q == CW'(CLR_DEPTH - 1));
  assign stat_o.scan_done  = (cmp_cnt_q == PW'(PROBE_LIMIT));
  assign stat_o.hit        = hit_q;
  assign stat_o.has_free   = free_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.mode       = mode_e'(in_q.mode);

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/ovwa_ctrl.sv =====
// Controller: sequences clearing, hashing, probing, table writes and accumulation.
`default_nettype none

module ovwa_ctrl import ovwa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output ovwa_cmd_t  cmd_o,
  input  ovwa_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH0,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_SCAN,
    S_ACT,
    S_ACC_RD,
    S_ACC_WR
  } state_e;

  state_e state_q;
  logic   pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pass_q  <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clear_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_HASH0;
            pass_q  <= 1'b0;
          end
        end
        S_HASH0: state_q <= S_HASH1;
        S_HASH1: state_q <= S_HASH2;
        S_HASH2: state_q <= S_HASH3;
        S_HASH3: state_q <= S_SCAN;
        S_SCAN: begin
          if (stat_i.scan_done) state_q <= S_ACT;
        end
        S_ACT: begin
          if ((stat_i.mode == MODE_REPLACE) && !pass_q) begin
            state_q <= S_HASH0;
            pass_q  <= 1'b1;
          end else begin
            state_q <= S_ACC_RD;
          end
        end
        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_ACC;
    cmd_o.key_sel = pass_q;
    case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE:  cmd_o.load  = in_valid_i;
      S_HASH0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_KL_CL;
        cmd_o.scan_clr = 1'b1;
      end
      S_HASH1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KH_CL;
        cmd_o.hash_op = HASH_LOAD;
      end
      S_HASH2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KL_CH;
        cmd_o.hash_op = HASH_ADD_HI;
      end
      S_HASH3: cmd_o.hash_op  = HASH_ADD_HI;
      S_SCAN:  cmd_o.scan_run = 1'b1;
      S_ACT: begin
        if (pass_q) begin
          // Second pass of a replace inserts the new reference.
          if (!stat_i.hit) begin
            if (stat_i.has_free) cmd_o.wr_kind = WR_INSERT;
            else cmd_o.set_full = 1'b1;
          end
        end else begin
          case (stat_i.mode)
            MODE_ADD, MODE_EXEC_PRICE, MODE_TRADE: begin
              if (!stat_i.hit) begin
                if (stat_i.has_free) cmd_o.wr_kind = WR_INSERT;
                else cmd_o.set_full = 1'b1;
              end
            end
            MODE_EXEC: begin
              cmd_o.set_miss = !stat_i.hit;
            end
            MODE_CANCEL, MODE_REPLACE, MODE_BROKEN: begin
              if (stat_i.hit) cmd_o.wr_kind = WR_ERASE;
              else cmd_o.set_miss = 1'b1;
            end
            default: begin
              if (stat_i.hit) cmd_o.wr_kind = WR_OVERWRITE;
              else if (stat_i.has_free) cmd_o.wr_kind = WR_INSERT;
              else cmd_o.set_full = 1'b1;
            end
          endcase
        end
      end
      S_ACC_RD: begin
        cmd_o.mul_en = 1'b1;
        case (stat_i.mode)
          MODE_EXEC:   cmd_o.acc_sel = stat_i.hit ? ACC_STORED_PRICE : ACC_NONE;
          MODE_BROKEN: cmd_o.acc_sel = stat_i.hit ? ACC_STORED_SUB : ACC_NONE;
          MODE_EXEC_PRICE, MODE_TRADE, MODE_CROSS: cmd_o.acc_sel = ACC_MSG;
          default: cmd_o.acc_sel = ACC_NONE;
        endcase
      end
      S_ACC_WR: cmd_o.acc_wr = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/order_table_vwap_accumulator.sv =====
// Top level of the order table with per-stock notional and volume totals.
`default_nettype none

// The block takes one parsed feed message per transfer on the input channel
// (in_valid_i, in_ready_o, in_i) and gives exactly one result per message on
// the output channel (out_valid_o, out_ready_i, out_o): a status and the
// stock's notional and volume totals after the message.
// Messages are handled one at a time. A lookup pass hashes the key on the
// shared 32x32 multiplier, scans the probe window through the table memory
// read port (one read issued per cycle, each compared in the next cycle) and
// then does the table write. After the lookup the product for the totals is
// formed and the accumulator write follows; only then is the block ready
// again, so it takes no new message before it is through with the last one.
// A replace runs two lookup passes, the second for the new reference.
// After reset the block sweeps both memories, one entry per cycle, through
// max(ORDER_SLOTS, STOCK_SLOTS) entries, and accepts no message meanwhile.
// The result sits in an output register. When the receiver stalls, the block
// still takes and works on the next message and only waits at its final
// accumulator write until the held result has been transferred.

`include "assert_macros.svh"

module order_table_vwap_accumulator import ovwa_pkg::*; #(
  parameter int unsigned ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int unsigned PROBE_LIMIT = PROBE_LIMIT_DEF,
  parameter int unsigned STOCK_SLOTS = STOCK_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ovwa_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ovwa_out_t out_o
);

  ovwa_cmd_t  cmd;
  ovwa_stat_t stat;

  // The controller decides what happens; the datapath holds all storage.
  ovwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  ovwa_dp #(
    .ORDER_SLOTS (ORDER_SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT),
    .STOCK_SLOTS (STOCK_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // No result can be pending while reset is held.
  `OVWA_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

  // After a transfer in, the block is busy with that message.
  `OVWA_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")

  // A result carries one of the three defined status codes.
  `OVWA_ASSERT(a_status_legal, out_valid_o |-> (out_o.status <= STAT_FULL), "bad status code")

endmodule

`default_nettype wire
